>>> sv/mxbsd_pkg.sv
package mxbsd_pkg;

    localparam int NUM_LANES   = 8;
    localparam int ACT_FLD_W   = 16;
    localparam int ACT_W       = ACT_FLD_W + 1;
    localparam int PROD_W      = 22;
    localparam int WS_W        = 25;
    localparam int BS_W        = 26;
    localparam int CNT_W       = 2;
    localparam int ROW_W       = 64;
    localparam int FIFO_DEPTH  = 8;
    localparam int FIFO_PTR_W  = 3;
    localparam int FIFO_CNT_W  = 4;
    localparam int IN_DATA_W   = 168;

    localparam logic [ROW_W-1:0] ROW_MAX = {1'b0, {(ROW_W-1){1'b1}}};
    localparam logic [ROW_W-1:0] ROW_MIN = {1'b1, {(ROW_W-1){1'b0}}};

    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [BS_W-1:0]   bsum_t;

    typedef struct packed {
        logic       valid;
        logic       last;
        logic       close;
        logic [7:0] scale;
    } ctl_t;

    typedef struct packed {
        logic [ROW_W-1:0] row_sum;
        logic             saturated;
    } res_t;

    // twice the e2m1 magnitude
    function automatic logic [3:0] mag2(input logic [2:0] code);
        logic [3:0] m;
        unique case (code)
            3'd0:    m = 4'd0;
            3'd1:    m = 4'd1;
            3'd2:    m = 4'd2;
            3'd3:    m = 4'd3;
            3'd4:    m = 4'd4;
            3'd5:    m = 4'd6;
            3'd6:    m = 4'd8;
            default: m = 4'd12;
        endcase
        return m;
    endfunction

endpackage

>>> sv/mxbsd_lane.sv
module mxbsd_lane #(
    parameter int ACT_BITS = 16
) (
    input  logic                               aclk,
    input  logic [3:0]                         nibble,
    input  logic [mxbsd_pkg::ACT_FLD_W-1:0]    act,
    output mxbsd_pkg::prod_t                   prod_reg
);

    logic signed [mxbsd_pkg::ACT_W-1:0]  act_val;
    logic                                act_sign;
    logic signed [mxbsd_pkg::PROD_W-1:0] mag_prod;
    mxbsd_pkg::prod_t                    prod_next;

    // sign bit sits at ACT_BITS-1; wider settings leave the field unsigned
    generate
        if (ACT_BITS <= mxbsd_pkg::ACT_FLD_W) begin : g_sext
            assign act_sign = act[ACT_BITS-1];
        end else begin : g_zext
            assign act_sign = 1'b0;
        end
    endgenerate

    always_comb begin
        for (int k = 0; k < mxbsd_pkg::ACT_W; k++) begin
            if (k < ACT_BITS && k < mxbsd_pkg::ACT_FLD_W) begin
                act_val[k] = act[k];
            end else begin
                act_val[k] = act_sign;
            end
        end
    end

    always_comb begin
        mag_prod  = mxbsd_pkg::PROD_W'(act_val * $signed({1'b0, mxbsd_pkg::mag2(nibble[2:0])}));
        prod_next = nibble[3] ? -mag_prod : mag_prod;
    end

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
    end

endmodule

>>> sv/mxbsd_merge.sv
module mxbsd_merge #(
    parameter int WORDS_PER_BLOCK = 4
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  mxbsd_pkg::ctl_t       ctl_in,
    input  mxbsd_pkg::prod_t      prods [mxbsd_pkg::NUM_LANES],
    output mxbsd_pkg::ctl_t       ctl_out_reg,
    output mxbsd_pkg::bsum_t      closed_reg
);

    logic signed [mxbsd_pkg::WS_W-1:0] word_sum;
    logic signed [mxbsd_pkg::WS_W-1:0] ws_reg;
    mxbsd_pkg::ctl_t                   ctl_b_reg;
    mxbsd_pkg::ctl_t                   ctl_out_next;
    mxbsd_pkg::bsum_t                  block_sum_reg;
    mxbsd_pkg::bsum_t                  block_sum_next;
    logic [mxbsd_pkg::CNT_W-1:0]       count_reg;
    logic                              close;

    always_comb begin
        word_sum = '0;
        for (int i = 0; i < mxbsd_pkg::NUM_LANES; i++) begin
            word_sum = word_sum + mxbsd_pkg::WS_W'(prods[i]);
        end
    end

    always_comb begin
        block_sum_next = block_sum_reg + mxbsd_pkg::BS_W'(ws_reg);
        close = (count_reg == mxbsd_pkg::CNT_W'(WORDS_PER_BLOCK - 1)) || ctl_b_reg.last;
        ctl_out_next       = ctl_b_reg;
        ctl_out_next.close = close;
    end

    always_ff @(posedge aclk) begin
        ws_reg     <= word_sum;
        closed_reg <= block_sum_next;
        if (!aresetn) begin
            ctl_b_reg     <= '0;
            ctl_out_reg   <= '0;
            block_sum_reg <= '0;
            count_reg     <= '0;
        end else begin
            ctl_b_reg   <= ctl_in;
            ctl_out_reg <= ctl_out_next;
            if (ctl_b_reg.valid) begin
                block_sum_reg <= close ? '0 : block_sum_next;
                count_reg     <= close ? '0 : count_reg + 1'b1;
            end
        end
    end

endmodule

>>> sv/mxbsd_rowacc.sv
module mxbsd_rowacc #(
    parameter int FRAC_BITS = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  mxbsd_pkg::ctl_t     ctl_in,
    input  mxbsd_pkg::bsum_t    closed,
    output logic                push,
    output mxbsd_pkg::res_t     push_data
);

    localparam int WIDE_W = mxbsd_pkg::BS_W + mxbsd_pkg::ROW_W - 1;
    localparam logic signed [9:0] SH_OFS = 10'(FRAC_BITS - 128);

    logic signed [9:0]                sh;
    logic [9:0]                       rneg;
    logic [4:0]                       rsh;
    logic [WIDE_W-1:0]                wide;
    mxbsd_pkg::bsum_t                 rshifted;
    logic [mxbsd_pkg::ROW_W-1:0]      bound;
    logic [mxbsd_pkg::ROW_W-1:0]      term_next;
    logic                             force_next;

    mxbsd_pkg::ctl_t                  ctl_d_reg;
    logic [mxbsd_pkg::ROW_W-1:0]      term_reg;
    logic                             force_reg;

    logic [mxbsd_pkg::ROW_W:0]        sum_wide;
    logic                             add_ovf;
    logic [mxbsd_pkg::ROW_W-1:0]      add_res;
    logic [mxbsd_pkg::ROW_W-1:0]      row_acc_reg;
    logic [mxbsd_pkg::ROW_W-1:0]      row_acc_next;
    logic                             sat_reg;
    logic                             sat_next;

    // scale the closed block sum by 2^(scale - 128 + FRAC_BITS)
    always_comb begin
        sh         = $signed({2'b00, ctl_in.scale}) + SH_OFS;
        rneg       = 10'(-sh);
        rsh        = (rneg >= 10'(mxbsd_pkg::BS_W - 1)) ? 5'(mxbsd_pkg::BS_W - 1) : rneg[4:0];
        wide       = {{(mxbsd_pkg::ROW_W-1){closed[mxbsd_pkg::BS_W-1]}}, closed}
                     << sh[5:0];
        rshifted   = closed >>> rsh;
        bound      = closed[mxbsd_pkg::BS_W-1] ? mxbsd_pkg::ROW_MIN : mxbsd_pkg::ROW_MAX;
        force_next = 1'b0;
        term_next  = '0;
        if (closed == '0) begin
            term_next = '0;
        end else if (!sh[9]) begin
            if (sh > 10'sd62) begin
                force_next = 1'b1;
            end else if (wide[WIDE_W-1:mxbsd_pkg::ROW_W-1]
                         != {(WIDE_W-mxbsd_pkg::ROW_W+1){wide[mxbsd_pkg::ROW_W-1]}}) begin
                force_next = 1'b1;
            end
            term_next = force_next ? bound : wide[mxbsd_pkg::ROW_W-1:0];
        end else begin
            term_next = {{(mxbsd_pkg::ROW_W-mxbsd_pkg::BS_W){rshifted[mxbsd_pkg::BS_W-1]}},
                         rshifted};
        end
    end

    // saturating row accumulate; an oversized block overwrites with the bound
    always_comb begin
        sum_wide     = {row_acc_reg[mxbsd_pkg::ROW_W-1], row_acc_reg}
                     + {term_reg[mxbsd_pkg::ROW_W-1], term_reg};
        add_ovf      = sum_wide[mxbsd_pkg::ROW_W] ^ sum_wide[mxbsd_pkg::ROW_W-1];
        add_res      = add_ovf ? (sum_wide[mxbsd_pkg::ROW_W] ? mxbsd_pkg::ROW_MIN
                                                            : mxbsd_pkg::ROW_MAX)
                               : sum_wide[mxbsd_pkg::ROW_W-1:0];
        row_acc_next = row_acc_reg;
        sat_next     = sat_reg;
        if (ctl_d_reg.valid && ctl_d_reg.close) begin
            if (force_reg) begin
                row_acc_next = term_reg;
                sat_next     = 1'b1;
            end else begin
                row_acc_next = add_res;
                sat_next     = sat_reg | add_ovf;
            end
        end
        push                = ctl_d_reg.valid && ctl_d_reg.last;
        push_data.row_sum   = row_acc_next;
        push_data.saturated = sat_next;
    end

    always_ff @(posedge aclk) begin
        term_reg  <= term_next;
        force_reg <= force_next;
        if (!aresetn) begin
            ctl_d_reg   <= '0;
            row_acc_reg <= '0;
            sat_reg     <= 1'b0;
        end else begin
            ctl_d_reg <= ctl_in;
            if (push) begin
                row_acc_reg <= '0;
                sat_reg     <= 1'b0;
            end else begin
                row_acc_reg <= row_acc_next;
                sat_reg     <= sat_next;
            end
        end
    end

endmodule

>>> sv/mxfp4_block_scaled_dot_product.sv
// the tlast item passes lane, word-sum, block-sum and term registers, then the queue
// throughput: one item per ready cycle through eight multiply lanes and a merge adder
// results wait in an 8-entry output queue; s_tready drops only with 8 rows undelivered
// reset (aresetn low, synchronous) clears the block and row sums, the word count,
// the saturation flag, all stage valids and the output queue
module mxfp4_block_scaled_dot_product #(
    parameter int FRAC_BITS       = 16,
    parameter int WORDS_PER_BLOCK = 4,
    parameter int ACT_BITS        = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // weight_word[31:0], block_scale[39:32], act_0[55:40] .. act_7[167:152]
    input  logic [mxbsd_pkg::IN_DATA_W-1:0]     s_tdata,
    input  logic                                s_tlast,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // row_sum[63:0]
    output logic [mxbsd_pkg::ROW_W-1:0]         m_tdata,
    // saturated[0]
    output logic                                m_tuser
);

    logic                                  accept;
    mxbsd_pkg::ctl_t                       ctl_a_reg;
    mxbsd_pkg::prod_t                      prods [mxbsd_pkg::NUM_LANES];
    mxbsd_pkg::ctl_t                       ctl_c;
    mxbsd_pkg::bsum_t                      closed;
    logic                                  push;
    mxbsd_pkg::res_t                       push_data;
    logic                                  pop;

    mxbsd_pkg::res_t                       fifo_mem [mxbsd_pkg::FIFO_DEPTH];
    logic [mxbsd_pkg::FIFO_PTR_W-1:0]      wr_ptr_reg;
    logic [mxbsd_pkg::FIFO_PTR_W-1:0]      rd_ptr_reg;
    logic [mxbsd_pkg::FIFO_CNT_W-1:0]      fifo_cnt_reg;
    logic [mxbsd_pkg::FIFO_CNT_W-1:0]      pending_reg;

    assign accept   = s_tvalid && s_tready;
    assign pop      = m_tvalid && m_tready;
    // rows accepted but not yet delivered reserve their queue entry
    assign s_tready = pending_reg < mxbsd_pkg::FIFO_CNT_W'(mxbsd_pkg::FIFO_DEPTH);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_a_reg <= '0;
        end else begin
            ctl_a_reg.valid <= accept;
            ctl_a_reg.last  <= s_tlast;
            ctl_a_reg.close <= 1'b0;
            ctl_a_reg.scale <= s_tdata[39:32];
        end
    end

    generate
        for (genvar i = 0; i < mxbsd_pkg::NUM_LANES; i++) begin : g_lane
            mxbsd_lane #(
                .ACT_BITS (ACT_BITS)
            ) u_lane (
                .aclk     (aclk),
                .nibble   (s_tdata[4*i +: 4]),
                .act      (s_tdata[40 + mxbsd_pkg::ACT_FLD_W*i +: mxbsd_pkg::ACT_FLD_W]),
                .prod_reg (prods[i])
            );
        end
    endgenerate

    mxbsd_merge #(
        .WORDS_PER_BLOCK (WORDS_PER_BLOCK)
    ) u_merge (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctl_in      (ctl_a_reg),
        .prods       (prods),
        .ctl_out_reg (ctl_c),
        .closed_reg  (closed)
    );

    mxbsd_rowacc #(
        .FRAC_BITS (FRAC_BITS)
    ) u_rowacc (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl_in    (ctl_c),
        .closed    (closed),
        .push      (push),
        .push_data (push_data)
    );

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_mem[wr_ptr_reg] <= push_data;
        end
        if (!aresetn) begin
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            fifo_cnt_reg <= '0;
            pending_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            fifo_cnt_reg <= fifo_cnt_reg + mxbsd_pkg::FIFO_CNT_W'(push)
                                         - mxbsd_pkg::FIFO_CNT_W'(pop);
            pending_reg  <= pending_reg + mxbsd_pkg::FIFO_CNT_W'(accept && s_tlast)
                                        - mxbsd_pkg::FIFO_CNT_W'(pop);
        end
    end

    assign m_tvalid = fifo_cnt_reg != '0;
    assign m_tdata  = fifo_mem[rd_ptr_reg].row_sum;
    assign m_tuser  = fifo_mem[rd_ptr_reg].saturated;

    a_pending_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        pending_reg <= mxbsd_pkg::FIFO_CNT_W'(mxbsd_pkg::FIFO_DEPTH))
        else $error("row reservations exceed queue depth");

    a_queue_within_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        fifo_cnt_reg <= pending_reg)
        else $error("queue holds more rows than were accepted");

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (fifo_cnt_reg < mxbsd_pkg::FIFO_CNT_W'(mxbsd_pkg::FIFO_DEPTH)))
        else $error("row written into a full queue");

    a_ready_after_reset: assert property (@(posedge aclk)
        !aresetn |=> s_tready && !m_tvalid)
        else $error("block not empty and ready after reset");

endmodule
